// ===== hw/rtl/isi_pkg.sv =====
// package for the image scale interpolator: constants and shared types
package isi_pkg;

  localparam int unsigned MaxSide   = 256;
  localparam int unsigned SideW     = $clog2(MaxSide);
  localparam int unsigned FracBits  = 16;
  localparam int unsigned StepW     = 23;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned PosW      = CoordW + StepW;
  localparam int unsigned SizeW     = SideW + 1;
  localparam int unsigned BankDepth = (MaxSide / 2) * (MaxSide / 2);
  localparam int unsigned BankAw    = 2 * SideW - 2;
  localparam int unsigned AddrW     = 3;

  typedef enum logic [AddrW-1:0] {
    REG_MODE       = 3'd0,
    REG_STEP_X     = 3'd1,
    REG_STEP_Y     = 3'd2,
    REG_SRC_WIDTH  = 3'd3,
    REG_SRC_HEIGHT = 3'd4
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              mode;
    logic [StepW-1:0]  step_x;
    logic [StepW-1:0]  step_y;
    logic [SideW-1:0]  last_x;
    logic [SideW-1:0]  last_y;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // horizontal/vertical edge handling derived per request
  typedef struct packed {
    logic             mode;
    logic             right;
    logic             bottom;
    logic [FracBits-1:0] u;
    logic [FracBits-1:0] v;
  } ctl_t;

endpackage

// ===== hw/rtl/isi_regs.sv =====
// configuration register file with APB-style access
module isi_regs import isi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic             mode_q;
  logic [StepW-1:0] step_x_q, step_y_q;
  logic [SizeW-1:0] width_q, height_q;
  logic             wr_en;
  logic [AddrW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      step_x_q <= StepW'(65536);
      step_y_q <= StepW'(65536);
      width_q  <= SizeW'(MaxSide);
      height_q <= SizeW'(MaxSide);
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_MODE:       mode_q   <= pwdata[0];
        REG_STEP_X:     step_x_q <= pwdata[StepW-1:0];
        REG_STEP_Y:     step_y_q <= pwdata[StepW-1:0];
        REG_SRC_WIDTH:  width_q  <= pwdata[SizeW-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_MODE:       prdata = {31'd0, mode_q};
        REG_STEP_X:     prdata = {{(32-StepW){1'b0}}, step_x_q};
        REG_STEP_Y:     prdata = {{(32-StepW){1'b0}}, step_y_q};
        REG_SRC_WIDTH:  prdata = {{(32-SizeW){1'b0}}, width_q};
        REG_SRC_HEIGHT: prdata = {{(32-SizeW){1'b0}}, height_q};
        default:        prdata = '0;
      endcase
    end
  end

  function automatic logic [SideW-1:0] last_idx(input logic [SizeW-1:0] s);
    logic [SideW-1:0] r;
    if (s == '0) r = '0;
    else if (s > SizeW'(MaxSide)) r = SideW'(MaxSide - 1);
    else r = SideW'(s - SizeW'(1));
    return r;
  endfunction

  assign cfg_o.mode   = mode_q;
  assign cfg_o.step_x = step_x_q;
  assign cfg_o.step_y = step_y_q;
  assign cfg_o.last_x = last_idx(width_q);
  assign cfg_o.last_y = last_idx(height_q);

endmodule

// ===== hw/rtl/isi_store.sv =====
// four-bank frame store by column and row parity, one read of each bank per cycle while en_i is high
module isi_store import isi_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [SideW-1:0]  wx_i,
  input  logic [SideW-1:0]  wy_i,
  input  rgb_t              wdata_i,
  input  logic [SideW-1:0]  x0_i,
  input  logic [SideW-1:0]  y0_i,
  input  logic [SideW-1:0]  x1_i,
  input  logic [SideW-1:0]  y1_i,
  output rgb_t              p1_o,
  output rgb_t              p2_o,
  output rgb_t              p3_o,
  output rgb_t              p4_o
);

  rgb_t mem0 [BankDepth];
  rgb_t mem1 [BankDepth];
  rgb_t mem2 [BankDepth];
  rgb_t mem3 [BankDepth];
  rgb_t rd_q [4];
  logic [BankAw-1:0] wa;
  logic [BankAw-1:0] ra [4];
  logic [1:0] wb;
  logic x0o_q, y0o_q;
  logic [SideW-1:0] xs [2];
  logic [SideW-1:0] ys [2];

  assign wa = {wy_i[SideW-1:1], wx_i[SideW-1:1]};
  assign wb = {wy_i[0], wx_i[0]};

  // bank k holds pixels with row parity k[1] and column parity k[0]
  always_comb begin
    if (x0_i[0]) begin
      xs[0] = x1_i; xs[1] = x0_i;
    end else begin
      xs[0] = x0_i; xs[1] = x1_i;
    end
    if (y0_i[0]) begin
      ys[0] = y1_i; ys[1] = y0_i;
    end else begin
      ys[0] = y0_i; ys[1] = y1_i;
    end
    ra[0] = {ys[0][SideW-1:1], xs[0][SideW-1:1]};
    ra[1] = {ys[0][SideW-1:1], xs[1][SideW-1:1]};
    ra[2] = {ys[1][SideW-1:1], xs[0][SideW-1:1]};
    ra[3] = {ys[1][SideW-1:1], xs[1][SideW-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i && wb == 2'd0) mem0[wa] <= wdata_i;
      if (we_i && wb == 2'd1) mem1[wa] <= wdata_i;
      if (we_i && wb == 2'd2) mem2[wa] <= wdata_i;
      if (we_i && wb == 2'd3) mem3[wa] <= wdata_i;
      rd_q[0] <= mem0[ra[0]];
      rd_q[1] <= mem1[ra[1]];
      rd_q[2] <= mem2[ra[2]];
      rd_q[3] <= mem3[ra[3]];
      x0o_q   <= x0_i[0];
      y0o_q   <= y0_i[0];
    end
  end

  always_comb begin
    p1_o = rd_q[{y0o_q,  x0o_q}];
    p2_o = rd_q[{y0o_q, ~x0o_q}];
    p3_o = rd_q[{~y0o_q,  x0o_q}];
    p4_o = rd_q[{~y0o_q, ~x0o_q}];
  end

endmodule

// ===== hw/rtl/isi_blend.sv =====
// one channel blend: a*(1-w)+b*w truncated to integer
module isi_blend import isi_pkg::*; (
  input  logic [7:0]          a_i,
  input  logic [7:0]          b_i,
  input  logic [FracBits-1:0] w_i,
  output logic [7:0]          y_o
);

  logic [FracBits:0]   wc;
  logic [FracBits+8:0] s;

  assign wc  = (FracBits+1)'(1 << FracBits) - {1'b0, w_i};
  assign s   = ({{(FracBits+1){1'b0}}, a_i} * {8'd0, wc}) +
               ({{(FracBits+1){1'b0}}, b_i} * {9'd0, w_i});
  assign y_o = s[FracBits+7:FracBits];

endmodule

// ===== hw/rtl/image_scale_interpolator_top.sv =====
// image scale interpolator top level: command pipeline, frame store and blend stages
//
// Loads write one RGB pixel into a 256x256 frame store split into four banks by row and column
// parity, so all four neighbours of a request are read together. One transaction is taken per
// cycle while s_axis_tready is high; a request passes the multiply, store address, store read,
// horizontal blend and vertical blend stages, and a load gives none. The pipeline holds only
// while m_axis_tready is low and the two-entry output skid buffer cannot absorb what is in flight.
module image_scale_interpolator_top import isi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command, pixel_x, pixel_y, in_red, in_green, in_blue
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0] m_axis_tdata
);

  cfg_t cfg;
  logic adv;
  logic [1:0] cnt_q, cnt_d;
  rgb_t skid_q [2];
  logic rd_ptr_q, wr_ptr_q;

  // stage 1: multiply
  logic             v1_q, cmd1_q;
  logic [PosW-1:0]  posx1_q, posy1_q;
  logic [CoordW-1:0] px1_q, py1_q;
  rgb_t             pix1_q;
  // stage 2: address
  logic             v2_q, req2_q, wr2_q;
  logic [SideW-1:0] x0_2_q, y0_2_q, x1_2_q, y1_2_q, wx2_q, wy2_q;
  rgb_t             pix2_q;
  ctl_t             ctl2_q;
  // stage 3: store read
  logic             v3_q;
  ctl_t             ctl3_q;
  rgb_t             p1, p2, p3, p4;
  // stage 4: horizontal
  logic             v4_q;
  ctl_t             ctl4_q;
  rgb_t             top4_q, bot4_q;
  rgb_t             top_c, bot_c, res_c;
  logic             v5_q;
  rgb_t             res5_q;

  logic             in_cmd;
  logic [CoordW-1:0] in_x, in_y;
  rgb_t             in_pix;

  assign in_cmd = s_axis_tdata[0];
  assign in_x   = s_axis_tdata[12:1];
  assign in_y   = s_axis_tdata[24:13];
  assign in_pix = {s_axis_tdata[32:25], s_axis_tdata[40:33], s_axis_tdata[48:41]};

  isi_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // the pipeline moves whenever the skid buffer can absorb everything in flight
  assign adv           = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !v5_q) || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q && req2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q  <= in_cmd;
      px1_q   <= in_x;
      py1_q   <= in_y;
      pix1_q  <= in_pix;
      posx1_q <= {{StepW{1'b0}}, in_x} * {{CoordW{1'b0}}, cfg.step_x};
      posy1_q <= {{StepW{1'b0}}, in_y} * {{CoordW{1'b0}}, cfg.step_y};
    end
  end

  // stage 2 address and edge logic
  logic [PosW-1:0]   rx, ry;
  logic [PosW-FracBits-1:0] ix_n, iy_n, ix_b, iy_b;
  logic [SideW-1:0]  nx, ny, bx, by;
  logic              right, bottom;

  assign rx   = posx1_q + PosW'(1 << (FracBits - 1));
  assign ry   = posy1_q + PosW'(1 << (FracBits - 1));
  assign ix_n = rx[PosW-1:FracBits];
  assign iy_n = ry[PosW-1:FracBits];
  assign ix_b = posx1_q[PosW-1:FracBits];
  assign iy_b = posy1_q[PosW-1:FracBits];
  assign nx   = (ix_n >= (PosW-FracBits)'(cfg.last_x)) ? cfg.last_x : ix_n[SideW-1:0];
  assign ny   = (iy_n >= (PosW-FracBits)'(cfg.last_y)) ? cfg.last_y : iy_n[SideW-1:0];
  assign right  = ix_b >= (PosW-FracBits)'(cfg.last_x);
  assign bottom = iy_b >= (PosW-FracBits)'(cfg.last_y);
  assign bx   = right  ? cfg.last_x : ix_b[SideW-1:0];
  assign by   = bottom ? cfg.last_y : iy_b[SideW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req2_q <= cmd1_q == CMD_REQUEST;
      wr2_q  <= v1_q && cmd1_q == CMD_LOAD &&
                px1_q < CoordW'(MaxSide) && py1_q < CoordW'(MaxSide);
      wx2_q  <= px1_q[SideW-1:0];
      wy2_q  <= py1_q[SideW-1:0];
      pix2_q <= pix1_q;
      if (cfg.mode) begin
        x0_2_q <= bx; y0_2_q <= by;
        x1_2_q <= bx + SideW'(1); y1_2_q <= by + SideW'(1);
      end else begin
        x0_2_q <= nx; y0_2_q <= ny;
        x1_2_q <= nx + SideW'(1); y1_2_q <= ny + SideW'(1);
      end
      ctl2_q.mode   <= cfg.mode;
      ctl2_q.right  <= right;
      ctl2_q.bottom <= bottom;
      ctl2_q.u      <= posx1_q[FracBits-1:0];
      ctl2_q.v      <= posy1_q[FracBits-1:0];
    end
  end

  isi_store u_store (
    .clk_i, .en_i(adv), .we_i(wr2_q), .wx_i(wx2_q), .wy_i(wy2_q), .wdata_i(pix2_q),
    .x0_i(x0_2_q), .y0_i(y0_2_q), .x1_i(x1_2_q), .y1_i(y1_2_q),
    .p1_o(p1), .p2_o(p2), .p3_o(p3), .p4_o(p4)
  );

  always_ff @(posedge clk_i) begin
    if (adv) ctl3_q <= ctl2_q;
  end

  // stage 4: horizontal blend; corner copies p1, right passes p1 and p3, bottom blends p1 with p2
  ctl_t hc;
  rgb_t ha, hb, la, lb;
  logic [FracBits-1:0] hw;
  always_comb begin
    hc = ctl3_q;
    ha = p1; hb = p2; la = p3; lb = p4; hw = hc.u;
    if (!hc.mode || (hc.right && hc.bottom)) begin
      hb = p1; la = p1; lb = p1; hw = '0;
    end else if (hc.right) begin
      hb = p1; la = p3; lb = p3; hw = '0;
    end else if (hc.bottom) begin
      la = p1; lb = p2;
    end
  end

  isi_blend u_hr0 (.a_i(ha.r), .b_i(hb.r), .w_i(hw), .y_o(top_c.r));
  isi_blend u_hg0 (.a_i(ha.g), .b_i(hb.g), .w_i(hw), .y_o(top_c.g));
  isi_blend u_hb0 (.a_i(ha.b), .b_i(hb.b), .w_i(hw), .y_o(top_c.b));
  isi_blend u_hr1 (.a_i(la.r), .b_i(lb.r), .w_i(hw), .y_o(bot_c.r));
  isi_blend u_hg1 (.a_i(la.g), .b_i(lb.g), .w_i(hw), .y_o(bot_c.g));
  isi_blend u_hb1 (.a_i(la.b), .b_i(lb.b), .w_i(hw), .y_o(bot_c.b));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl4_q <= ctl3_q;
      top4_q <= top_c;
      bot4_q <= bot_c;
    end
  end

  // stage 5: vertical blend; the bottom edge already holds its result in both rows
  logic [FracBits-1:0] vw;
  assign vw = (ctl4_q.mode && !ctl4_q.bottom) ? ctl4_q.v : '0;

  isi_blend u_vr (.a_i(top4_q.r), .b_i(bot4_q.r), .w_i(vw), .y_o(res_c.r));
  isi_blend u_vg (.a_i(top4_q.g), .b_i(bot4_q.g), .w_i(vw), .y_o(res_c.g));
  isi_blend u_vb (.a_i(top4_q.b), .b_i(bot4_q.b), .w_i(vw), .y_o(res_c.b));

  always_ff @(posedge clk_i) begin
    if (adv) res5_q <= res_c;
  end

  // output skid fifo, two entries
  logic push, pop;
  assign push = adv && v5_q;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) skid_q[wr_ptr_q] <= res5_q;
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {skid_q[rd_ptr_q].b, skid_q[rd_ptr_q].g, skid_q[rd_ptr_q].r};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !m_axis_tready) |-> !push) else $error("push into full skid");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(res5_q) && $stable(v5_q)) else $error("stage 5 moved under stall");

endmodule
